// File: rtl/trle_pkg.sv
// Package for the threshold run-length encoder: result type, output queue
// sizing, register indexes and register reset values. No dependencies.
package trle_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;

    localparam logic [8:0]  THRESHOLD_RST    = 9'd8;
    localparam logic [7:0]  BLOCK_LENGTH_RST = 8'd16;
    localparam logic [15:0] IMAGE_WIDTH_RST  = 16'd640;

    typedef struct packed {
        logic [7:0] run_value;
        logic [7:0] run_length;
        logic       block_end;
        logic       last;
    } t_result;

    // up to two results are pushed per accepted item, first slot first
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

// File: rtl/trle_out_fifo.sv
// Output queue of the threshold run-length encoder: takes up to two results
// a cycle, hands out one. Depends on trle_pkg.
module trle_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  trle_pkg::t_push  i_push,
    output logic             o_room2,   // space for two more results
    output logic             o_valid,
    input  logic             i_ready,
    output trle_pkg::t_result o_res
);
    import trle_pkg::*;

    t_result             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp;
    logic [FIFO_AW-1:0]  r_rp;
    logic [FIFO_CW-1:0]  r_count;
    logic [FIFO_AW-1:0]  wp_next;
    logic                pop;
    logic [FIFO_CW-1:0]  push_n;

    assign wp_next = FIFO_AW'(r_wp + 1'b1);
    assign pop     = o_valid && i_ready;
    assign push_n  = FIFO_CW'(i_push.valid0) + FIFO_CW'(i_push.valid1);
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rp];
    assign o_room2 = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.valid1) begin
            r_mem[wp_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= FIFO_AW'(r_wp + push_n[FIFO_AW-1:0]);
            r_rp    <= FIFO_AW'(r_rp + pop);
            r_count <= FIFO_CW'(r_count + push_n - FIFO_CW'(pop));
        end
    end

endmodule

// File: rtl/threshold_run_length_encoder.sv
// Threshold run-length encoder: one 8-bit pixel per item in, (value, length)
// runs out. Each result is written into the output queue when its pixel is
// taken. Throughput: one pixel per cycle while input is ready; a pixel that
// yields two results fills two slots of a 4-entry output queue (input ready
// while two slots are free). Sync active-low reset clears run state, counters,
// queue and sets threshold 8, block length 16, image width 640.
module threshold_run_length_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // pixel input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] pixel_value
    // run output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,    // [7:0] run_value, [15:8] run_length
    output logic        o_m_tuser,    // [0] block_end
    output logic        o_m_tlast     // last result of the pixel
);
    import trle_pkg::*;

    // configuration
    logic [8:0]  r_threshold;
    logic [7:0]  r_block_length;
    logic [15:0] r_image_width;

    // run / position state
    logic [7:0]  r_run_start;
    logic [7:0]  r_run_count;
    logic        r_run_open;
    logic [7:0]  r_pos;
    logic [15:0] r_col;

    logic        s_accept;
    logic [7:0]  pix;
    logic [7:0]  diff;
    logic        joins;
    logic        broken;
    logic [7:0]  n_run_start;
    logic [7:0]  n_run_count;
    logic [7:0]  pos_inc;
    logic [15:0] col_inc;
    logic [7:0]  bl_eff;
    logic [15:0] iw_eff;
    logic        row_end;
    logic        blk_end;
    logic        close;
    t_push       push;
    t_result     res_old;
    t_result     res_close;
    t_result     out_res;
    logic        room2;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = room2;
    assign pix        = i_s_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RST;
            r_block_length <= BLOCK_LENGTH_RST;
            r_image_width  <= IMAGE_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_THRESHOLD:    r_threshold    <= i_cfg_wdata[8:0];
                REG_BLOCK_LENGTH: r_block_length <= i_cfg_wdata[7:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // pixel vs. run start: join while |p - start| < threshold
    assign diff   = (pix >= r_run_start) ? 8'(pix - r_run_start)
                                         : 8'(r_run_start - pix);
    assign joins  = r_run_open && ({1'b0, diff} < r_threshold);
    assign broken = r_run_open && !joins;

    assign n_run_start = joins ? r_run_start : pix;
    assign n_run_count = joins ? 8'(r_run_count + 8'd1) : 8'd1;

    // zero limits behave as one; a lowered limit closes at once (>=)
    assign bl_eff  = (r_block_length == '0) ? 8'd1 : r_block_length;
    assign iw_eff  = (r_image_width == '0) ? 16'd1 : r_image_width;
    assign pos_inc = 8'(r_pos + 8'd1);
    assign col_inc = 16'(r_col + 16'd1);
    assign row_end = (col_inc >= iw_eff) || (col_inc == '0);
    assign blk_end = (pos_inc >= bl_eff) || (pos_inc == '0);
    assign close   = row_end || blk_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_start <= '0;
            r_run_count <= '0;
            r_run_open  <= 1'b0;
            r_pos       <= '0;
            r_col       <= '0;
        end else if (s_accept) begin
            r_run_start <= n_run_start;
            r_run_count <= close ? 8'd0 : n_run_count;
            r_run_open  <= !close;
            r_pos       <= close ? 8'd0 : pos_inc;
            r_col       <= row_end ? 16'd0 : col_inc;
        end
    end

    // broken run goes first; the block/row close result follows it
    always_comb begin
        res_old.run_value    = r_run_start;
        res_old.run_length   = r_run_count;
        res_old.block_end    = 1'b0;
        res_old.last         = !close;
        res_close.run_value  = n_run_start;
        res_close.run_length = n_run_count;
        res_close.block_end  = 1'b1;
        res_close.last       = 1'b1;
        push.valid0 = s_accept && (broken || close);
        push.valid1 = s_accept && broken && close;
        push.res0   = broken ? res_old : res_close;
        push.res1   = res_close;
    end

    trle_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {out_res.run_length, out_res.run_value};
    assign o_m_tuser = out_res.block_end;
    assign o_m_tlast = out_res.last;

`ifndef SYNTHESIS
    // a run is open exactly when the block has started
    a_open_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_open == (r_pos != 8'd0))
        else $error("run open flag out of step with block position");

    // emitted runs are never empty
    a_len_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:8] != 8'd0))
        else $error("zero-length run on output");

    // a two-result pixel leaves something to send next cycle
    a_two_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid1 |=> o_m_tvalid)
        else $error("two results pushed but output empty");

    // no run is counted while none is open
    a_closed_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run_open |-> (r_run_count == 8'd0))
        else $error("run count held with no open run");
`endif

endmodule

// File: tb/tb_threshold_run_length_encoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for threshold_run_length_encoder: pixel items in,
// (value, length) runs out, each run checked against a run predictor.
// Depends on trle_pkg and the encoder RTL only.
module tb_threshold_run_length_encoder;
    import trle_pkg::*;

    localparam int QUIET_LIMIT = 3000;  // cycles with nothing moving

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    threshold_run_length_encoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),     // [7:0] pixel_value
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),     // [7:0] run_value, [15:8] run_length
        .o_m_tuser   (m_tuser),     // [0] block_end
        .o_m_tlast   (m_tlast)
    );

    // register mirror
    logic [8:0]  thr_reg   = THRESHOLD_RST;
    logic [7:0]  blen_reg  = BLOCK_LENGTH_RST;
    logic [15:0] width_reg = IMAGE_WIDTH_RST;

    // encoder state mirror
    logic [7:0]  run_first = '0;
    logic [7:0]  run_len   = '0;
    bit          run_open  = 1'b0;
    logic [7:0]  blk_pos   = '0;
    logic [15:0] col       = '0;

    t_result     runs_due[$];
    int          errors        = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req      = 0;
    logic [7:0]  scene         = 8'd128;

    initial begin
        forever #5 clk = ~clk;
    end

    // Predict the runs one accepted pixel closes; a break comes before a close.
    task automatic encode_pixel(input logic [7:0] px);
        logic [7:0]  blk_lim;
        logic [15:0] row_lim;
        logic [8:0]  diff;
        t_result     broken;
        t_result     closed;
        bit          have_broken;
        bit          close;
        blk_lim     = (blen_reg == 0) ? 8'd1 : blen_reg;
        row_lim     = (width_reg == 0) ? 16'd1 : width_reg;
        have_broken = 1'b0;
        if (run_open) begin
            diff = (px >= run_first) ? {1'b0, px} - {1'b0, run_first}
                                     : {1'b0, run_first} - {1'b0, px};
            if (diff < thr_reg) begin
                run_len = run_len + 8'd1;
            end else begin
                broken.run_value  = run_first;
                broken.run_length = run_len;
                broken.block_end  = 1'b0;
                broken.last       = 1'b1;
                have_broken       = 1'b1;
                run_first         = px;
                run_len           = 8'd1;
            end
        end else begin
            run_open  = 1'b1;
            run_first = px;
            run_len   = 8'd1;
        end
        blk_pos = blk_pos + 8'd1;
        col     = col + 16'd1;
        close   = 1'b0;
        // >= so that a limit lowered mid-row or mid-block closes at once
        if (col >= row_lim || col == 0) begin
            col   = '0;
            close = 1'b1;
        end
        if (blk_pos >= blk_lim || blk_pos == 0)
            close = 1'b1;
        if (have_broken) begin
            broken.last = !close;
            runs_due.push_back(broken);
        end
        if (close) begin
            closed.run_value  = run_first;
            closed.run_length = run_len;
            closed.block_end  = 1'b1;
            closed.last       = 1'b1;
            runs_due.push_back(closed);
            run_open = 1'b0;
            run_len  = '0;
            blk_pos  = '0;
        end
    endtask

    // Offer one pixel after a random gap; returns at the edge it is taken.
    task automatic send_pixel(input logic [7:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
        encode_pixel(px);
    endtask

    // we is lowered after the write edge, so back-to-back writes never collide
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_THRESHOLD:    thr_reg   = val[8:0];
            REG_BLOCK_LENGTH: blen_reg  = val[7:0];
            REG_IMAGE_WIDTH:  width_reg = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait for every predicted run, then let the encoder
    // settle, since a joining pixel makes no run.
    task automatic drain_runs();
        s_tvalid <= 1'b0;
        while (runs_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Mostly smooth regions around a drifting level, some pure noise.
    function automatic logic [7:0] next_pixel();
        int r;
        int spread;
        int v;
        r = $urandom_range(99);
        if (r < 12)
            return 8'($urandom_range(255));
        if (r < 25)
            scene = 8'($urandom_range(255));
        spread = (thr_reg > 1 && thr_reg < 64) ? int'(thr_reg) : 6;
        v = int'(scene) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    task automatic pick_settings();
        logic [15:0] v;
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
                0: v = 16'd0;
                1: v = 16'd1;
                2: v = 16'd255;
                3: v = 16'd256;
                4: v = 16'($urandom_range(511));
                default: v = 16'($urandom_range(2, 40));
            endcase
            write_reg(REG_THRESHOLD, v);
        end
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
                0: v = 16'd0;
                1: v = 16'd1;
                2: v = 16'd255;
                3: v = 16'($urandom_range(255));
                default: v = 16'($urandom_range(1, 24));
            endcase
            write_reg(REG_BLOCK_LENGTH, v);
        end
        if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
                0: v = 16'd0;
                1: v = 16'd1;
                2: v = 16'd65535;
                3: v = 16'($urandom_range(65535));
                default: v = 16'($urandom_range(1, 80));
            endcase
            write_reg(REG_IMAGE_WIDTH, v);
        end
    endtask

    // reset values: joins below 8, breaks at exactly 8, both pixel extremes
    task automatic test_reset_values();
        send_pixel(8'd0);
        send_pixel(8'd7);
        send_pixel(8'd8);
        send_pixel(8'd255);
        send_pixel(8'd248);
        send_pixel(8'd247);
        drain_runs();
    endtask

    // threshold 0 never joins, 256 joins everything
    task automatic test_threshold_extremes();
        write_reg(REG_THRESHOLD, 16'd0);
        send_pixel(8'd10);
        send_pixel(8'd10);
        send_pixel(8'd10);
        drain_runs();
        write_reg(REG_THRESHOLD, 16'd256);
        send_pixel(8'd0);
        send_pixel(8'd255);
        drain_runs();
    endtask

    // block length and row width lowered below the current count
    task automatic test_limit_lowered();
        write_reg(REG_THRESHOLD, 16'd4);
        write_reg(REG_BLOCK_LENGTH, 16'd200);
        write_reg(REG_IMAGE_WIDTH, 16'd1000);
        repeat (4) send_pixel(8'd100);
        drain_runs();
        write_reg(REG_BLOCK_LENGTH, 16'd2);
        send_pixel(8'd20);      // breaks the run and closes the block
        drain_runs();
        write_reg(REG_BLOCK_LENGTH, 16'd100);
        repeat (3) send_pixel(8'd60);
        drain_runs();
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        send_pixel(8'd61);
        drain_runs();
    endtask

    // zero block length and zero width both act as one
    task automatic test_zero_sizes();
        write_reg(REG_THRESHOLD, 16'd8);
        write_reg(REG_BLOCK_LENGTH, 16'd0);
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd128);
        drain_runs();
    endtask

    // one run filling a whole 255-pixel block
    task automatic test_longest_run();
        write_reg(REG_THRESHOLD, 16'd256);
        write_reg(REG_BLOCK_LENGTH, 16'd255);
        write_reg(REG_IMAGE_WIDTH, 16'd65535);
        repeat (255) send_pixel(8'($urandom_range(255)));
        drain_runs();
    endtask

    task automatic test_random_stream(input int n_items, input int snd_pct,
                                      input int rcv_pct);
        int sent;
        int seg;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        sent = 0;
        while (sent < n_items) begin
            pick_settings();
            seg = $urandom_range(4, 40);
            if (seg > n_items - sent)
                seg = n_items - sent;
            repeat (seg) send_pixel(next_pixel());
            sent += seg;
            drain_runs();
        end
    endtask

    // receiver holds off long enough for the output queue to fill and the
    // input to stall; then the sender waits for every run
    task automatic test_backpressure();
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_BLOCK_LENGTH, 16'd3);
        write_reg(REG_IMAGE_WIDTH, 16'd7);
        hold_req = 300;
        repeat (30) send_pixel(next_pixel());
        drain_runs();
    endtask

    // receiver: random stalls, plus a counted hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic void check_field(input string name, input int want,
                                        input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, want, got);
            errors++;
        end
    endfunction

    // run checker and watchdog
    initial begin
        int      quiet;
        t_result want;
        quiet = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                if (runs_due.size() == 0) begin
                    $display({"%0t: unexpected run: expected none, actual value %0d",
                              " length %0d block_end %0b last %0b"},
                             $time, m_tdata[7:0], m_tdata[15:8], m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = runs_due.pop_front();
                    check_field("run_value", int'(want.run_value),
                                int'(m_tdata[7:0]));
                    check_field("run_length", int'(want.run_length),
                                int'(m_tdata[15:8]));
                    check_field("block_end", int'(want.block_end), int'(m_tuser));
                    check_field("last", int'(want.last), int'(m_tlast));
                end
            end
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: watchdog: nothing moved for %0d cycles", $time, quiet);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 8;
        recv_idle_pct = 74;
        test_reset_values();
        test_threshold_extremes();
        test_limit_lowered();
        test_zero_sizes();
        test_longest_run();
        test_random_stream(45, 8, 74);
        test_random_stream(45, 74, 8);
        test_random_stream(45, 0, 0);
        test_backpressure();
        drain_runs();
        repeat (5) @(posedge clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
